// ===== design/icy_pkg.sv =====
// ----------------------------------------------------------------------------
// icy_pkg
// Shared types, byte codes and the title key for the ICY metadata deframer.
// ----------------------------------------------------------------------------
package icy_pkg;

   localparam int unsigned IvalBits  = 24;
   localparam int unsigned AddrBits  = 12;
   localparam int unsigned KeyLen    = 11;

   // result byte classes
   localparam logic [1:0] CLS_AUDIO   = 2'd0;
   localparam logic [1:0] CLS_LENGTH  = 2'd1;
   localparam logic [1:0] CLS_META    = 2'd2;
   localparam logic [1:0] CLS_RESTART = 2'd3;

   // parser delimiters
   localparam logic [7:0] CHR_Q    = 8'h27;
   localparam logic [7:0] CHR_EQ   = 8'h3D;
   localparam logic [7:0] CHR_SEMI = 8'h3B;

   // one classified beat handed from front to back
   typedef struct packed {
      logic [1:0]          cls;
      logic [7:0]          data;
      logic                bend;
      logic                wr;
      logic [AddrBits-1:0] wr_addr;
      logic                parse;
      logic [AddrBits-1:0] n;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EQ,
      ST_AFT,
      ST_SEMI,
      ST_QT,
      ST_END,
      ST_CHK,
      ST_SA,
      ST_SB,
      ST_DONE
   } state_type;

   // "StreamTitle", one character per index
   function automatic logic [7:0] title_key(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h53;
         4'd1:    c = 8'h74;
         4'd2:    c = 8'h72;
         4'd3:    c = 8'h65;
         4'd4:    c = 8'h61;
         4'd5:    c = 8'h6D;
         4'd6:    c = 8'h54;
         4'd7:    c = 8'h69;
         4'd8:    c = 8'h74;
         4'd9:    c = 8'h6C;
         4'd10:   c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== design/icy_front.sv =====
// ----------------------------------------------------------------------------
// icy_front
// Accepts stream beats, tracks the audio interval and block position, and
// emits one classified job per beat.
// ----------------------------------------------------------------------------
module icy_front import icy_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [IvalBits-1:0] csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_stream_byte,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job
);

   logic [IvalBits-1:0] ival_ff, ival_in;
   logic [IvalBits-1:0] left_ff, left_in;
   logic [AddrBits-1:0] len_ff, len_in;
   logic [AddrBits-1:0] pos_ff, pos_in;
   logic [AddrBits-1:0] pos_inc;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign pos_inc   = pos_ff + 1'b1;

   // classify the beat and advance the framing counters
   always_comb begin
      ival_in = csr_wr_en ? csr_wr_data : ival_ff;
      left_in = left_ff;
      len_in  = len_ff;
      pos_in  = pos_ff;
      q_job   = '0;
      q_job.data = req_stream_byte;
      priority if (req_kind) begin
         left_in    = ival_ff;
         len_in     = '0;
         pos_in     = '0;
         q_job.cls  = CLS_RESTART;
         q_job.data = '0;
      end else if (ival_ff == '0) begin
         q_job.cls = CLS_AUDIO;
      end else if (left_ff != '0) begin
         left_in   = left_ff - 1'b1;
         q_job.cls = CLS_AUDIO;
      end else if (len_ff == '0) begin
         q_job.cls = CLS_LENGTH;
         len_in    = {req_stream_byte, 4'b0000};
         pos_in    = '0;
         if (req_stream_byte == 8'd0) begin
            left_in    = ival_ff;
            q_job.bend = 1'b1;
         end
      end else begin
         q_job.cls     = CLS_META;
         q_job.wr      = 1'b1;
         q_job.wr_addr = pos_ff;
         pos_in        = pos_inc;
         if (pos_inc >= len_ff) begin
            q_job.bend  = 1'b1;
            q_job.parse = 1'b1;
            q_job.n     = len_ff;
            len_in      = '0;
            pos_in      = '0;
            left_in     = ival_ff;
         end
      end
   end

   // hold framing state; update the counters on an accepted beat and the interval on a CSR write
   always_ff @(posedge clock) begin
      if (reset) begin
         ival_ff <= '0;
         left_ff <= '0;
         len_ff  <= '0;
         pos_ff  <= '0;
      end else begin
         ival_ff <= ival_in;
         if (q_push) begin
            left_ff <= left_in;
            len_ff  <= len_in;
            pos_ff  <= pos_in;
         end
      end
   end

endmodule

// ===== design/icy_queue.sv =====
// ----------------------------------------------------------------------------
// icy_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module icy_queue import icy_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_job
);

   job_type    slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full    = (cnt_ff == 2'd2);
   assign valid   = (cnt_ff != 2'd0);
   assign pop_job = slot_ff[rp_ff];

   // store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== design/icy_back.sv =====
// ----------------------------------------------------------------------------
// icy_back
// Executes jobs: stores metadata bytes, scans a finished block for the
// stream title one stored byte at a time, and drives the result register.
// ----------------------------------------------------------------------------
module icy_back import icy_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  job_type             q_job,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_byte_class,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_block_end,
   output logic                rsp_title_found,
   output logic [AddrBits-1:0] rsp_title_offset,
   output logic [AddrBits-1:0] rsp_title_length
);

   logic [7:0] mem [2**AddrBits];
   logic [7:0] rdata_ff;
   logic [AddrBits-1:0] raddr;

   state_type state_ff, state_in;
   logic ph_ff, ph_in;
   logic [AddrBits-1:0] n_ff, n_in, pos_ff, pos_in, i_ff, i_in;
   logic [AddrBits-1:0] eq_ff, eq_in, vs_ff, vs_in, endq_ff, endq_in;
   logic [AddrBits-1:0] lastq_ff, lastq_in;
   logic mism_ff, mism_in, title_ff, title_in, pq_ff, pq_in, sq_ff, sq_in;
   job_type jb_ff, jb_in;

   logic rv_ff, rv_in;
   logic [1:0] rcls_ff, rcls_in;
   logic [7:0] rdat_ff, rdat_in;
   logic rbend_ff, rbend_in, rfound_ff, rfound_in;
   logic [AddrBits-1:0] roff_ff, roff_in, rlen_ff, rlen_in;
   logic found_ff, found_in;
   logic [AddrBits-1:0] off_ff, off_in, len_ff, len_in;

   logic free, strip;
   logic [AddrBits-1:0] key_pos, s_val, e_val;

   assign rsp_valid        = rv_ff;
   assign rsp_byte_class   = rcls_ff;
   assign rsp_data_byte    = rdat_ff;
   assign rsp_block_end    = rbend_ff;
   assign rsp_title_found  = rfound_ff;
   assign rsp_title_offset = roff_ff;
   assign rsp_title_length = rlen_ff;

   assign free    = !rv_ff || rsp_ready;
   assign key_pos = i_ff - pos_ff;

   // strip one pair of wrapping quotes
   assign strip = ((endq_ff - vs_ff) >= AddrBits'(2)) && sq_ff && (rdata_ff == CHR_Q);
   assign s_val = strip ? vs_ff + 1'b1 : vs_ff;
   assign e_val = strip ? endq_ff - 1'b1 : endq_ff;

   // select the scan address
   always_comb begin
      unique case (state_ff)
         ST_AFT:  raddr = eq_ff + 1'b1;
         ST_SA:   raddr = vs_ff;
         ST_SB:   raddr = endq_ff - 1'b1;
         default: raddr = i_ff;
      endcase
   end

   // write stored bytes, register the read
   always_ff @(posedge clock) begin
      if (q_pop && q_job.wr) begin
         mem[q_job.wr_addr] <= q_job.data;
      end
      rdata_ff <= mem[raddr];
   end

   // parser and result control
   always_comb begin
      state_in = state_ff;  ph_in = ph_ff;
      n_in = n_ff;  pos_in = pos_ff;  i_in = i_ff;  eq_in = eq_ff;
      vs_in = vs_ff;  endq_in = endq_ff;  lastq_in = lastq_ff;
      mism_in = mism_ff;  title_in = title_ff;  pq_in = pq_ff;  sq_in = sq_ff;
      jb_in = jb_ff;
      found_in = found_ff;  off_in = off_ff;  len_in = len_ff;
      rv_in = rv_ff;  rcls_in = rcls_ff;  rdat_in = rdat_ff;  rbend_in = rbend_ff;
      rfound_in = rfound_ff;  roff_in = roff_ff;  rlen_in = rlen_ff;
      q_pop = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && free) begin
               q_pop = 1'b1;
               if (q_job.parse) begin
                  jb_in = q_job;  n_in = q_job.n;
                  pos_in = '0;  i_in = '0;  mism_in = 1'b0;  ph_in = 1'b0;
                  state_in = ST_EQ;
               end else begin
                  rv_in = 1'b1;  rcls_in = q_job.cls;  rdat_in = q_job.data;
                  rbend_in = q_job.bend;  rfound_in = 1'b0;
                  roff_in = '0;  rlen_in = '0;
               end
            end
         end
         ST_EQ: begin
            if (!ph_ff) begin
               if (i_ff >= n_ff) begin
                  found_in = 1'b0;  off_in = '0;  len_in = '0;  state_in = ST_DONE;
               end else ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (rdata_ff == CHR_EQ) begin
                  eq_in = i_ff;
                  title_in = !mism_ff && (key_pos == AddrBits'(KeyLen));
                  if ((i_ff + 1'b1) >= n_ff) begin
                     found_in = 1'b0;  off_in = '0;  len_in = '0;  state_in = ST_DONE;
                  end else state_in = ST_AFT;
               end else begin
                  if (key_pos < AddrBits'(KeyLen) && rdata_ff != title_key(key_pos[3:0]))
                     mism_in = 1'b1;
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_AFT: begin
            if (!ph_ff) ph_in = 1'b1;
            else begin
               ph_in = 1'b0;
               if (rdata_ff == CHR_Q) begin
                  vs_in = eq_ff + 2'd2;  i_in = eq_ff + 2'd2;  state_in = ST_QT;
               end else begin
                  i_in = eq_ff + 1'b1;  state_in = ST_SEMI;
               end
            end
         end
         ST_SEMI: begin
            if (!ph_ff) begin
               if (i_ff >= n_ff) begin
                  found_in = 1'b0;  off_in = '0;  len_in = '0;  state_in = ST_DONE;
               end else ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               i_in = i_ff + 1'b1;
               if (rdata_ff == CHR_SEMI) begin
                  pos_in = i_ff + 1'b1;  mism_in = 1'b0;  state_in = ST_EQ;
               end
            end
         end
         ST_QT: begin
            if (!ph_ff) begin
               if (i_ff >= n_ff) begin
                  found_in = 1'b0;  off_in = '0;  len_in = '0;  state_in = ST_DONE;
               end else ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               i_in = i_ff + 1'b1;
               if (rdata_ff == CHR_Q) begin
                  lastq_in = i_ff;  pq_in = 1'b1;  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (!ph_ff) begin
               if (i_ff >= n_ff) begin
                  endq_in = lastq_ff;  state_in = ST_CHK;
               end else ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (pq_ff && rdata_ff == CHR_SEMI) begin
                  endq_in = i_ff - 1'b1;  state_in = ST_CHK;
               end else begin
                  if (rdata_ff == CHR_Q) lastq_in = i_ff;
                  pq_in = (rdata_ff == CHR_Q);
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_CHK: begin
            if (title_ff) state_in = ST_SA;
            else begin
               i_in = endq_ff + 1'b1;  state_in = ST_SEMI;
            end
         end
         ST_SA: begin
            if (!ph_ff) ph_in = 1'b1;
            else begin
               ph_in = 1'b0;  sq_in = (rdata_ff == CHR_Q);  state_in = ST_SB;
            end
         end
         ST_SB: begin
            if (!ph_ff) ph_in = 1'b1;
            else begin
               ph_in = 1'b0;
               if (e_val > s_val) begin
                  found_in = 1'b1;  off_in = s_val;  len_in = e_val - s_val;
                  state_in = ST_DONE;
               end else begin
                  i_in = endq_ff + 1'b1;  state_in = ST_SEMI;
               end
            end
         end
         ST_DONE: begin
            if (free) begin
               rv_in = 1'b1;  rcls_in = jb_ff.cls;  rdat_in = jb_ff.data;
               rbend_in = jb_ff.bend;  rfound_in = found_ff;
               roff_in = off_ff;  rlen_in = len_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         rv_ff    <= rv_in;
      end
   end

   // hold scan and result payload
   always_ff @(posedge clock) begin
      n_ff <= n_in;  pos_ff <= pos_in;  i_ff <= i_in;  eq_ff <= eq_in;
      vs_ff <= vs_in;  endq_ff <= endq_in;  lastq_ff <= lastq_in;
      mism_ff <= mism_in;  title_ff <= title_in;  pq_ff <= pq_in;  sq_ff <= sq_in;
      jb_ff <= jb_in;  found_ff <= found_in;  off_ff <= off_in;  len_ff <= len_in;
      rcls_ff <= rcls_in;  rdat_ff <= rdat_in;  rbend_ff <= rbend_in;
      rfound_ff <= rfound_in;  roff_ff <= roff_in;  rlen_ff <= rlen_in;
   end

`ifndef SYNTHESIS
   a_title_on_end: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rfound_ff |-> rbend_ff && (rcls_ff == CLS_META))
      else $error("title reported off a block end");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !q_pop)
      else $error("job popped while parsing");
   a_restart_clean: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rcls_ff == CLS_RESTART |-> rdat_ff == 8'd0 && !rbend_ff)
      else $error("restart result not clean");
`endif

endmodule

// ===== design/icy_metadata_deframer.sv =====
// ----------------------------------------------------------------------------
// icy_metadata_deframer
// ICY stream deframer: classifies bytes and reports the stream title.
// ----------------------------------------------------------------------------
// A plain beat's result is registered in the job queue and then in the result
// register after the beat is accepted; a block's last byte adds a scan over
// the block store. The block takes one beat per cycle outside scans while
// rsp_ready does not hold the result; the single block store read port paces
// the scan. Reset is synchronous and clears framing and handshake state; the
// block store is not cleared.
module icy_metadata_deframer import icy_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [IvalBits-1:0] csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_stream_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_byte_class,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_block_end,
   output logic                rsp_title_found,
   output logic [AddrBits-1:0] rsp_title_offset,
   output logic [AddrBits-1:0] rsp_title_length
);

   logic    q_full, q_push, q_valid, q_pop;
   job_type push_job, pop_job;

   icy_front u_front (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_ready, .req_kind, .req_stream_byte,
      .q_full, .q_push, .q_job(push_job)
   );

   icy_queue u_queue (
      .clock, .reset, .push(q_push), .push_job, .full(q_full),
      .pop(q_pop), .valid(q_valid), .pop_job
   );

   icy_back u_back (
      .clock, .reset, .q_valid, .q_job(pop_job), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_byte_class, .rsp_data_byte,
      .rsp_block_end, .rsp_title_found, .rsp_title_offset, .rsp_title_length
   );

endmodule
